// ----- hw/rtl/fas_pkg.sv -----
`default_nettype none
package fas_pkg;
    localparam logic [31:0] SIGN_MASK = 32'h8000_0000;
    localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
    localparam logic [22:0] FRAC_MASK = 23'h7F_FFFF;

    typedef enum logic {CMD_ADD = 1'b0, CMD_SUB = 1'b1} cmd_t;

    // leading-zero count of a 24-bit value (0..24)
    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        logic       hit;
        n   = 5'd24;
        hit = 1'b0;
        for (int i = 23; i >= 0; i--)
        begin
            if (!hit && v[i])
            begin
                n   = 5'(23 - i);
                hit = 1'b1;
            end
        end
        return n;
    endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/fas_datapath.sv -----
`default_nettype none
module fas_datapath (
    input  wire logic        cmd,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b_in,
    output logic      [31:0] res
);
    import fas_pkg::*;

    logic [31:0] b, big, sml;
    logic [7:0]  eb, es;
    logic [7:0]  gap;
    logic [23:0] mbig, msml, mal;
    logic [24:0] sum;
    logic [23:0] diff, dn;
    logic [4:0]  lz;
    logic        same;
    logic signed [10:0] e;
    logic [22:0] frac;
    logic        sgn;

    always_comb begin
        b    = (cmd == CMD_SUB) ? (b_in ^ SIGN_MASK) : b_in;
        same = (a[31] == b[31]);
        // same-sign path picks bigger exponent; ties keep a as big
        if (same) begin
            if (a[30:23] < b[30:23]) begin
                big = b; sml = a;
            end else begin
                big = a; sml = b;
            end
        end else begin
            if (a[30:0] < b[30:0]) begin
                big = b; sml = a;
            end else begin
                big = a; sml = b;
            end
        end
        eb   = big[30:23];
        es   = sml[30:23];
        gap  = eb - es;
        mbig = {1'b1, big[22:0]};
        msml = {1'b1, sml[22:0]};
        mal  = (gap >= 8'd24) ? 24'd0 : (msml >> gap[4:0]);
        sum  = {1'b0, mbig} + {1'b0, mal};
        diff = mbig - mal;
        lz   = lzc24(diff);
        dn   = diff << lz;
        if (same) begin
            sgn  = b[31];
            if (sum[24]) begin
                e    = 11'(eb) + 11'sd1;
                frac = sum[23:1];
            end else begin
                e    = 11'(eb);
                frac = sum[22:0];
            end
        end else begin
            sgn  = big[31];
            e    = 11'(eb) - 11'(lz);
            frac = dn[22:0];
        end
        if (!same && diff == 24'd0)
            res = 32'd0;
        else if (e > 11'sd254)
            res = {sgn, 31'd0} | INF_BITS;
        else if (e < 11'sd1)
            res = {sgn, 31'd0};
        else
            res = {sgn, e[7:0], frac & FRAC_MASK};
    end
endmodule
`default_nettype wire

// ----- hw/rtl/float32_add_sub_truncating_top.sv -----
// Single-precision add/subtract, truncating, no special-value handling.
// Input channel: in_valid/in_ready carry cmd (0 add, 1 subtract),
// operand_a and operand_b. Output channel: out_valid/out_ready carry
// sum_bits.
// Operands are latched into an input register; the arithmetic is one
// combinational pass into the result register, and out_valid comes
// from the result register's valid flag. Throughput one operation per
// cycle while the receiver does not stall, set by the single pass
// between the two registers.
// Each stage advances when the stage after it is empty or moving, so a
// stalled receiver holds the result and backs up at most two items
// before in_ready drops.
// Reset clears both valid flags; payload registers are not reset.
`default_nettype none
module float32_add_sub_truncating_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        cmd,
    input  wire logic [31:0] operand_a,
    input  wire logic [31:0] operand_b,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [31:0] sum_bits
);
    import fas_pkg::*;

    logic        s1_vld_reg, s2_vld_reg;
    logic        cmd_reg;
    logic [31:0] a_reg, b_reg, res_reg, res_next;
    logic        adv2, adv1;

    assign adv2     = s1_vld_reg && (!s2_vld_reg || out_ready);
    assign in_ready = !s1_vld_reg || adv2;
    assign adv1     = in_valid && in_ready;

    fas_datapath u_dp (
        .cmd (cmd_reg),
        .a   (a_reg),
        .b_in(b_reg),
        .res (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready) s1_vld_reg <= in_valid;
            if (!s2_vld_reg || out_ready) s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            cmd_reg <= cmd;
            a_reg   <= operand_a;
            b_reg   <= operand_b;
        end
        if (adv2) res_reg <= res_next;
    end

    assign out_valid = s2_vld_reg;
    assign sum_bits  = res_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sum_bits))
        else $error("result changed under stall");
    a_nodrop: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg && s2_vld_reg && !out_ready |-> !in_ready)
        else $error("input accepted with pipeline full");
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        adv2 |=> s2_vld_reg)
        else $error("advanced item lost");
endmodule
`default_nettype wire

// ----- test/float32_add_sub_truncating_top_test.sv -----
`default_nettype none
module float32_add_sub_truncating_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import fas_pkg::*;

    typedef struct packed {
        cmd_t        op;
        logic [31:0] a;
        logic [31:0] b;
    } fop_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        cmd;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] sum_bits;

    fop_t        pending_ops[$];
    logic [31:0] expected_sums[$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;
    bit          send_paused;

    float32_add_sub_truncating_top dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .operand_a(operand_a), .operand_b(operand_b),
        .out_valid(out_valid), .out_ready(out_ready), .sum_bits(sum_bits)
    );

    function automatic logic [31:0] fadd_trunc(fop_t op);
        logic [31:0] a, b, big, sml;
        logic [31:0] sign;
        int          ea, eb, e, gap, n;
        logic [31:0] ma, mb, s, d;
        a = op.a;
        b = op.b;
        if (op.op == CMD_SUB)
            b = b ^ 32'h8000_0000;
        if (a[31] == b[31])
        begin
            ea = int'(a[30:23]);
            eb = int'(b[30:23]);
            ma = {8'd0, 1'b1, a[22:0]};
            mb = {8'd0, 1'b1, b[22:0]};
            if (ea < eb)
            begin
                gap = eb - ea;
                ma = (gap >= 24) ? 32'd0 : ma >> gap;
                e = eb;
            end
            else
            begin
                gap = ea - eb;
                mb = (gap >= 24) ? 32'd0 : mb >> gap;
                e = ea;
            end
            s = ma + mb;
            if (s[24])
            begin
                s = s >> 1;
                e = e + 1;
            end
            sign = {b[31], 31'd0};
            d = s;
        end
        else
        begin
            big = a;
            sml = b;
            if (a[30:0] < b[30:0])
            begin
                big = b;
                sml = a;
            end
            gap = int'(big[30:23]) - int'(sml[30:23]);
            ma = {8'd0, 1'b1, big[22:0]};
            mb = {8'd0, 1'b1, sml[22:0]};
            mb = (gap >= 24) ? 32'd0 : mb >> gap;
            d = ma - mb;
            if (d == 0)
                return 32'd0;
            n = 0;
            for (int i = 0; i < 32; i++)
                if (d[i])
                    n = i + 1;
            d = d << (24 - n);
            e = int'(big[30:23]) - (24 - n);
            sign = {big[31], 31'd0};
        end
        if (e > 254)
            return sign | 32'h7F80_0000;
        if (e < 1)
            return sign;
        return sign | (32'(e) << 23) | (d & 32'h007F_FFFF);
    endfunction

    function automatic logic [31:0] rand_float();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 5))
            0: v[30:23] = 8'd0;
            1: v[30:23] = 8'd255;
            2: v[30:23] = 8'd254;
            3: v[30:23] = 8'd1;
            default: ;
        endcase
        return v;
    endfunction

    task automatic queue_op(cmd_t c, logic [31:0] a, logic [31:0] b);
        fop_t op;
        op.op = c;
        op.a = a;
        op.b = b;
        pending_ops.push_back(op);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd <= 1'b0;
            operand_a <= 32'd0;
            operand_b <= 32'd0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_ops.size() > 0 && !send_paused &&
                $urandom_range(0, 99) >= send_idle_pct)
            begin
                fop_t op;
                op = pending_ops.pop_front();
                expected_sums.push_back(fadd_trunc(op));
                in_valid <= 1'b1;
                cmd <= op.op;
                operand_a <= op.a;
                operand_b <= op.b;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver ready, with a long hold-off when requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_sums.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", sum_bits);
            end
            else
            begin
                logic [31:0] want;
                want = expected_sums.pop_front();
                if (sum_bits !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("sum_bits mismatch: expected %h got %h", want, sum_bits);
                end
            end
        end
    end

    task automatic drain();
        while (pending_ops.size() > 0 || expected_sums.size() > 0 || in_valid)
            @(posedge clk);
    endtask

    task automatic add_random(int count);
        for (int i = 0; i < count; i++)
        begin
            logic [31:0] a, b;
            a = rand_float();
            b = rand_float();
            case ($urandom_range(0, 7))
                0: b = a;
                1: b = a ^ 32'h8000_0000;
                2: b = {$urandom_range(0, 1) == 1, a[30:0] ^ 31'($urandom_range(0, 7))};
                3: b[30:23] = a[30:23] + 8'($urandom_range(0, 3));
                default: ;
            endcase
            queue_op(cmd_t'($urandom_range(0, 1)), a, b);
        end
    endtask

    initial
    begin
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        send_paused = 1'b0;

        // directed: both ops, cancellation, overflow, underflow, big gap, specials
        queue_op(CMD_ADD, 32'h3F80_0000, 32'h3F80_0000);
        queue_op(CMD_SUB, 32'h3F80_0000, 32'h3F80_0000);
        queue_op(CMD_ADD, 32'h3F80_0000, 32'hBF80_0000);
        queue_op(CMD_SUB, 32'hC020_0000, 32'h4020_0000);
        queue_op(CMD_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
        queue_op(CMD_SUB, 32'hFF7F_FFFF, 32'h7F7F_FFFF);
        queue_op(CMD_SUB, 32'h0080_0001, 32'h0080_0000);
        queue_op(CMD_SUB, 32'h8080_0000, 32'h8080_0001);
        queue_op(CMD_ADD, 32'h4B80_0000, 32'h3F80_0000);
        queue_op(CMD_ADD, 32'h4C00_0000, 32'h3F80_0000);
        queue_op(CMD_SUB, 32'h7F80_0000, 32'h0000_0000);
        queue_op(CMD_ADD, 32'h0000_0000, 32'h0000_0000);
        queue_op(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_op(CMD_SUB, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        queue_op(CMD_ADD, 32'h7FC0_0000, 32'h3F80_0000);
        queue_op(CMD_SUB, 32'h3F80_0000, 32'h3F7F_FFFF);
        queue_op(CMD_ADD, 32'h4000_0000, 32'hBFFF_FFFF);
        queue_op(CMD_ADD, 32'h5555_5555, 32'hAAAA_AAAA);
        queue_op(CMD_SUB, 32'h0000_0001, 32'h0000_0000);
        queue_op(CMD_ADD, 32'h3FFF_FFFF, 32'h3FFF_FFFF);
        @(posedge rst_n);
        drain();

        // long receiver hold-off while the sender keeps offering
        add_random(40);
        hold_cycles = 60;
        drain();

        send_paused = 1'b1;
        add_random(20);
        repeat (20) @(posedge clk);
        send_paused = 1'b0;
        drain();

        add_random(300);
        drain();
        send_idle_pct = 85;
        add_random(300);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 85;
        add_random(300);
        drain();
        send_idle_pct = 11;
        recv_stall_pct = 11;
        add_random(300);
        drain();

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// ----- float32_add_sub_truncating_top.f -----
hw/rtl/fas_pkg.sv
hw/rtl/fas_datapath.sv
hw/rtl/float32_add_sub_truncating_top.sv
test/float32_add_sub_truncating_top_test.sv
